// ===== rtl/core/scps_pkg.sv =====
// Shared types, codes and phase tables for the stepper coil phase sequencer.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package scps_pkg;

    localparam int CoilCount = 4;

    typedef logic [CoilCount-1:0] coil_t;

    // opcodes of an input item
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_STEP_MODE   = 2'd0,
        REG_PHASE_DELAY = 2'd1,
        REG_START_DELAY = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_HALF = 2'd0,
        MODE_FULL = 2'd1,
        MODE_WAVE = 2'd2,
        MODE_BAD  = 2'd3
    } step_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_RUNNING  = 3'd1,
        ST_DONE     = 3'd2,
        ST_STOPPED  = 3'd3,
        ST_BADCOUNT = 3'd4,
        ST_BADMODE  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        STAGE_IDLE = 3'b001,
        STAGE_WAIT = 3'b010,
        STAGE_RUN  = 3'b100
    } stage_t;

    typedef struct packed {
        coil_t       coil;
        logic [2:0]  phase;
        logic [14:0] passes;
        logic [15:0] ticks;
        stage_t      stage;
        logic        rev;
        status_t     status;
        step_mode_t  mode;
    } seq_state_t;

    typedef struct packed {
        step_mode_t  step_mode;
        logic [15:0] phase_delay;
        logic [15:0] start_delay;
    } seq_cfg_t;

    typedef struct packed {
        coil_t   coil;
        logic    busy;
        status_t status;
    } result_t;

    function automatic coil_t phase_pattern(input step_mode_t mode, input logic rev,
                                            input logic [2:0] idx);
        logic [2:0] i;
        coil_t      pat;
        begin
            i = (mode == MODE_HALF) ? idx : {1'b0, idx[1:0]};
            if (rev)
                i = (mode == MODE_HALF) ? (3'd7 - i) : (3'd3 - i);
            case (mode)
                MODE_HALF:
                begin
                    case (i)
                        3'd0: pat = 4'd1;
                        3'd1: pat = 4'd3;
                        3'd2: pat = 4'd2;
                        3'd3: pat = 4'd6;
                        3'd4: pat = 4'd4;
                        3'd5: pat = 4'd12;
                        3'd6: pat = 4'd8;
                        default: pat = 4'd9;
                    endcase
                end
                MODE_FULL:
                begin
                    case (i[1:0])
                        2'd0: pat = 4'd3;
                        2'd1: pat = 4'd6;
                        2'd2: pat = 4'd12;
                        default: pat = 4'd9;
                    endcase
                end
                default:
                begin
                    case (i[1:0])
                        2'd0: pat = 4'd1;
                        2'd1: pat = 4'd2;
                        2'd2: pat = 4'd4;
                        default: pat = 4'd8;
                    endcase
                end
            endcase
            return pat;
        end
    endfunction

endpackage

// ===== rtl/core/scps_next_state.sv =====
// Next-state logic for one item: start, tick and stop handling.
// Depends on scps_pkg.
`timescale 1ns / 1ps

module scps_next_state (
    input  scps_pkg::seq_state_t cur,
    input  scps_pkg::seq_cfg_t   cfg,
    input  scps_pkg::opcode_t    opcode,
    input  logic signed [15:0]   step_count,
    input  logic                 counter_clockwise,
    output scps_pkg::seq_state_t nxt
);

    logic [15:0] tick_inc;
    logic [15:0] hold;
    logic [3:0]  phase_inc;
    logic [3:0]  tab_len;
    logic [2:0]  phase_new;
    logic [14:0] passes_new;

    assign tick_inc  = cur.ticks + 16'd1;
    assign hold      = (cfg.phase_delay == 16'd0) ? 16'd1 : cfg.phase_delay;
    assign phase_inc = {1'b0, cur.phase} + 4'd1;
    assign tab_len   = (cur.mode == scps_pkg::MODE_HALF) ? 4'd8 : 4'd4;
    assign phase_new = (phase_inc >= tab_len) ? 3'd0 : phase_inc[2:0];
    assign passes_new = (phase_inc >= tab_len) ? (cur.passes - 15'd1) : cur.passes;

    always_comb
    begin
        nxt = cur;
        case (opcode)
            scps_pkg::OP_START:
            begin
                if (cur.stage == scps_pkg::STAGE_IDLE)
                begin
                    if (step_count[15])
                    begin
                        nxt.coil   = '0;
                        nxt.ticks  = '0;
                        nxt.phase  = '0;
                        nxt.status = scps_pkg::ST_BADCOUNT;
                    end
                    else if (cfg.step_mode == scps_pkg::MODE_BAD)
                    begin
                        nxt.coil   = '0;
                        nxt.ticks  = '0;
                        nxt.phase  = '0;
                        nxt.status = scps_pkg::ST_BADMODE;
                    end
                    else
                    begin
                        nxt.mode   = cfg.step_mode;
                        nxt.rev    = counter_clockwise;
                        nxt.passes = step_count[14:0];
                        nxt.phase  = '0;
                        nxt.ticks  = '0;
                        nxt.coil   = '0;
                        nxt.stage  = scps_pkg::STAGE_WAIT;
                        nxt.status = scps_pkg::ST_RUNNING;
                        // no start delay: first phase shows in this result, or a zero count finishes at once
                        if (cfg.start_delay == 16'd0)
                        begin
                            if (step_count[14:0] == 15'd0)
                            begin
                                nxt.stage  = scps_pkg::STAGE_IDLE;
                                nxt.status = scps_pkg::ST_DONE;
                            end
                            else
                            begin
                                nxt.stage = scps_pkg::STAGE_RUN;
                                nxt.coil  = scps_pkg::phase_pattern(cfg.step_mode,
                                                counter_clockwise, 3'd0);
                            end
                        end
                    end
                end
            end
            scps_pkg::OP_STOP:
            begin
                nxt.coil = '0;
                if (cur.stage != scps_pkg::STAGE_IDLE)
                begin
                    nxt.stage  = scps_pkg::STAGE_IDLE;
                    nxt.ticks  = '0;
                    nxt.phase  = '0;
                    nxt.status = scps_pkg::ST_STOPPED;
                end
            end
            scps_pkg::OP_TICK:
            begin
                if (cur.stage == scps_pkg::STAGE_WAIT)
                begin
                    nxt.ticks = tick_inc;
                    if (tick_inc >= cfg.start_delay)
                    begin
                        nxt.ticks = '0;
                        nxt.phase = '0;
                        if (cur.passes == 15'd0)
                        begin
                            nxt.coil   = '0;
                            nxt.stage  = scps_pkg::STAGE_IDLE;
                            nxt.status = scps_pkg::ST_DONE;
                        end
                        else
                        begin
                            nxt.coil   = scps_pkg::phase_pattern(cur.mode, cur.rev, 3'd0);
                            nxt.stage  = scps_pkg::STAGE_RUN;
                            nxt.status = scps_pkg::ST_RUNNING;
                        end
                    end
                end
                else if (cur.stage == scps_pkg::STAGE_RUN)
                begin
                    nxt.ticks = tick_inc;
                    if (tick_inc >= hold)
                    begin
                        nxt.ticks  = '0;
                        nxt.phase  = phase_new;
                        nxt.passes = passes_new;
                        if (phase_new == 3'd0 && passes_new == 15'd0)
                        begin
                            nxt.coil   = '0;
                            nxt.stage  = scps_pkg::STAGE_IDLE;
                            nxt.status = scps_pkg::ST_DONE;
                        end
                        else
                        begin
                            nxt.coil = scps_pkg::phase_pattern(cur.mode, cur.rev, phase_new);
                        end
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== rtl/core/scps_out_buf.sv =====
// Two-entry output buffer for result items; keeps input accepting while
// one result waits. Depends on scps_pkg.
`timescale 1ns / 1ps

module scps_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  scps_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output scps_pkg::result_t out_data
);

    scps_pkg::result_t slot0_reg, slot0_next;
    scps_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
                slot0_next = push_data;
            else
                slot1_next = push_data;
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (pop && push)
        begin
            if (count_reg == 2'd1)
                slot0_next = push_data;
            else
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== rtl/core/stepper_coil_phase_sequencer.sv =====
// Top level of the stepper coil phase sequencer: config registers, sequencer
// state and result buffer. Depends on scps_pkg, scps_next_state, scps_out_buf.
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, opcode, step_count,    into block
//            counter_clockwise
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  into block
//   out      out_valid/out_ready, coil_drive,          out of block
//            busy_res, status
//
// One item per cycle while in_ready is high; each result is registered into
// the result buffer as its item is accepted. Reset clears the sequencer state
// to idle with coils low. The two-entry result buffer lets one result wait
// while the next item is taken; in_ready drops only when both entries are held.
`timescale 1ns / 1ps

module stepper_coil_phase_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [15:0] step_count,
    input  logic               counter_clockwise,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         coil_drive,
    output logic               busy_res,
    output logic [2:0]         status
);

    scps_pkg::seq_state_t state_reg, state_next;
    scps_pkg::seq_cfg_t   cfg_reg, cfg_next;
    scps_pkg::result_t    res_push, res_out;
    logic                 buf_full;
    logic                 accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !buf_full;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (scps_pkg::reg_index_t'(cfg_index))
                scps_pkg::REG_STEP_MODE:   cfg_next.step_mode = scps_pkg::step_mode_t'(cfg_data[1:0]);
                scps_pkg::REG_PHASE_DELAY: cfg_next.phase_delay = cfg_data;
                scps_pkg::REG_START_DELAY: cfg_next.start_delay = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    scps_next_state u_next (
        .cur               (state_reg),
        .cfg               (cfg_reg),
        .opcode            (scps_pkg::opcode_t'(opcode)),
        .step_count        (step_count),
        .counter_clockwise (counter_clockwise),
        .nxt               (state_next)
    );

    assign res_push.coil   = state_next.coil;
    assign res_push.busy   = (state_next.stage != scps_pkg::STAGE_IDLE);
    assign res_push.status = state_next.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_mode   <= scps_pkg::MODE_HALF;
            cfg_reg.phase_delay <= 16'd1;
            cfg_reg.start_delay <= 16'd0;
            state_reg.coil      <= '0;
            state_reg.phase     <= '0;
            state_reg.passes    <= '0;
            state_reg.ticks     <= '0;
            state_reg.stage     <= scps_pkg::STAGE_IDLE;
            state_reg.rev       <= 1'b0;
            state_reg.status    <= scps_pkg::ST_IDLE;
            state_reg.mode      <= scps_pkg::MODE_HALF;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (accept)
                state_reg <= state_next;
        end
    end

    scps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res_push),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res_out)
    );

    assign coil_drive = res_out.coil;
    assign busy_res   = res_out.busy;
    assign status     = res_out.status;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the stepper coil phase sequencer: scoreboard class with
// its own sequencer model, plus handshake tasks. Depends on scps_pkg and the RTL top.
`timescale 1ns / 1ps

class coil_scoreboard;
    scps_pkg::step_mode_t cfg_mode;
    logic [15:0]          cfg_phase_delay;
    logic [15:0]          cfg_start_delay;

    scps_pkg::coil_t      coil;
    logic [2:0]           phase;
    logic [14:0]          passes;
    logic [15:0]          ticks;
    scps_pkg::stage_t     stage;
    logic                 rev;
    scps_pkg::status_t    last_st;
    scps_pkg::step_mode_t mode_held;

    scps_pkg::coil_t half_seq[8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    scps_pkg::coil_t full_seq[4] = '{4'h3, 4'h6, 4'hC, 4'h9};
    scps_pkg::coil_t wave_seq[4] = '{4'h1, 4'h2, 4'h4, 4'h8};

    scps_pkg::result_t expected_q[$];
    int                errors;

    function new();
        cfg_mode        = scps_pkg::MODE_HALF;
        cfg_phase_delay = 16'd1;
        cfg_start_delay = 16'd0;
        coil            = '0;
        phase           = '0;
        passes          = '0;
        ticks           = '0;
        stage           = scps_pkg::STAGE_IDLE;
        rev             = 1'b0;
        last_st         = scps_pkg::ST_IDLE;
        mode_held       = scps_pkg::MODE_HALF;
        errors          = 0;
    endfunction

    function void set_register(scps_pkg::reg_index_t idx, logic [15:0] data);
        case (idx)
            scps_pkg::REG_STEP_MODE:   cfg_mode = scps_pkg::step_mode_t'(data[1:0]);
            scps_pkg::REG_PHASE_DELAY: cfg_phase_delay = data;
            scps_pkg::REG_START_DELAY: cfg_start_delay = data;
            default: ;
        endcase
    endfunction

    function int seq_len();
        return (mode_held == scps_pkg::MODE_HALF) ? 8 : 4;
    endfunction

    function scps_pkg::coil_t pattern_of(int idx);
        int n;
        int i;
        n = seq_len();
        i = idx % n;
        if (rev)
            i = n - 1 - i;
        case (mode_held)
            scps_pkg::MODE_HALF: return half_seq[i];
            scps_pkg::MODE_FULL: return full_seq[i];
            default:             return wave_seq[i];
        endcase
    endfunction

    function void halt(scps_pkg::status_t st);
        coil    = '0;
        stage   = scps_pkg::STAGE_IDLE;
        ticks   = '0;
        phase   = '0;
        last_st = st;
    endfunction

    function void start_phases();
        if (passes == 0)
        begin
            halt(scps_pkg::ST_DONE);
            return;
        end
        phase   = '0;
        ticks   = '0;
        coil    = pattern_of(0);
        stage   = scps_pkg::STAGE_RUN;
        last_st = scps_pkg::ST_RUNNING;
    endfunction

    // predict the result of one accepted item
    function void note_input(logic [1:0] op, logic [15:0] cnt, logic ccw);
        logic [15:0]       hold;
        int                next_phase;
        scps_pkg::result_t r;
        case (scps_pkg::opcode_t'(op))
            scps_pkg::OP_START:
            begin
                if (stage == scps_pkg::STAGE_IDLE)
                begin
                    if (cnt[15])
                        halt(scps_pkg::ST_BADCOUNT);
                    else if (cfg_mode == scps_pkg::MODE_BAD)
                        halt(scps_pkg::ST_BADMODE);
                    else
                    begin
                        mode_held = cfg_mode;
                        rev       = ccw;
                        passes    = cnt[14:0];
                        phase     = '0;
                        ticks     = '0;
                        coil      = '0;
                        stage     = scps_pkg::STAGE_WAIT;
                        last_st   = scps_pkg::ST_RUNNING;
                        if (cfg_start_delay == 0)
                            start_phases();
                    end
                end
            end
            scps_pkg::OP_STOP:
            begin
                if (stage != scps_pkg::STAGE_IDLE)
                    halt(scps_pkg::ST_STOPPED);
                else
                    coil = '0;
            end
            scps_pkg::OP_TICK:
            begin
                if (stage == scps_pkg::STAGE_WAIT)
                begin
                    ticks = ticks + 16'd1;
                    if (ticks >= cfg_start_delay)
                        start_phases();
                end
                else if (stage == scps_pkg::STAGE_RUN)
                begin
                    hold  = (cfg_phase_delay == 0) ? 16'd1 : cfg_phase_delay;
                    ticks = ticks + 16'd1;
                    if (ticks >= hold)
                    begin
                        ticks      = '0;
                        next_phase = phase + 1;
                        if (next_phase >= seq_len())
                        begin
                            next_phase = 0;
                            passes     = passes - 15'd1;
                        end
                        phase = next_phase[2:0];
                        if (phase == 0 && passes == 0)
                            halt(scps_pkg::ST_DONE);
                        else
                            coil = pattern_of(phase);
                    end
                end
            end
            default: ;
        endcase
        r.coil   = coil;
        r.busy   = (stage != scps_pkg::STAGE_IDLE);
        r.status = last_st;
        expected_q.push_back(r);
    endfunction

    function void check_result(scps_pkg::coil_t c, logic b, logic [2:0] s);
        scps_pkg::result_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: coil=%h busy=%b status=%0d", c, b, s);
            return;
        end
        want = expected_q.pop_front();
        if (c !== want.coil || b !== want.busy || s !== want.status)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: coil %h/%h busy %b/%b status %0d/%0d (exp/got)",
                         want.coil, c, want.busy, b, want.status, s);
        end
    endfunction
endclass

module testbench;
    localparam int QuietLimit = 2000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic signed [15:0] step_count;
    logic               counter_clockwise;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               out_valid;
    logic               out_ready;
    logic [3:0]         coil_drive;
    logic               busy_res;
    logic [2:0]         status;

    coil_scoreboard       sb;
    bit                   calm;
    int                   quiet_cycles;
    scps_pkg::step_mode_t cur_mode;
    logic [15:0]          cur_phase_delay;
    logic [15:0]          cur_start_delay;

    stepper_coil_phase_sequencer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .step_count        (step_count),
        .counter_clockwise (counter_clockwise),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .coil_drive        (coil_drive),
        .busy_res          (busy_res),
        .status            (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end

    // result check first: it belongs to an earlier item than any taken this edge
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if (out_valid && out_ready)
                sb.check_result(coil_drive, busy_res, status);
            if (in_valid && in_ready)
                sb.note_input(opcode, step_count, counter_clockwise);
            if (cfg_valid && cfg_ready)
                sb.set_register(scps_pkg::reg_index_t'(cfg_index), cfg_data);
            if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QuietLimit)
            @(posedge clk);
        $display("testbench: errors");
        $finish;
    end

    function automatic logic [15:0] any16();
        return 16'($urandom());
    endfunction

    task automatic send_item(scps_pkg::opcode_t op, logic [15:0] cnt, logic ccw);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 4)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        opcode            <= op;
        step_count        <= cnt;
        counter_clockwise <= ccw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // sender holds off until every predicted result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(scps_pkg::reg_index_t idx, logic [15:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            scps_pkg::REG_STEP_MODE:   cur_mode = scps_pkg::step_mode_t'(data[1:0]);
            scps_pkg::REG_PHASE_DELAY: cur_phase_delay = data;
            scps_pkg::REG_START_DELAY: cur_start_delay = data;
            default: ;
        endcase
    endtask

    initial
    begin
        int          sent;
        int          pick;
        int          n_ticks;
        int          plen;
        longint      need;
        logic [15:0] cnt;
        logic [15:0] word;
        logic        ccw;

        sb              = new();
        calm            = 1'b0;
        cur_mode        = scps_pkg::MODE_HALF;
        cur_phase_delay = 16'd1;
        cur_start_delay = 16'd0;
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        opcode            <= scps_pkg::OP_TICK;
        step_count        <= '0;
        counter_clockwise <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_index         <= scps_pkg::REG_STEP_MODE;
        cfg_data          <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle: tick, unused opcode and stop change nothing
        send_item(scps_pkg::OP_TICK, any16(), 1'b1);
        send_item(scps_pkg::OP_NONE, any16(), 1'b0);
        send_item(scps_pkg::OP_STOP, any16(), 1'b1);
        // negative count refused
        send_item(scps_pkg::OP_START, 16'h8000, 1'b0);
        // invalid mode refused at once
        write_reg(scps_pkg::REG_STEP_MODE, 16'(scps_pkg::MODE_BAD));
        send_item(scps_pkg::OP_START, 16'd1, 1'b0);
        // zero phase delay acts as one tick; reversed half step; start while busy
        write_reg(scps_pkg::REG_STEP_MODE, 16'(scps_pkg::MODE_HALF));
        write_reg(scps_pkg::REG_PHASE_DELAY, 16'd0);
        send_item(scps_pkg::OP_START, 16'd1, 1'b1);
        send_item(scps_pkg::OP_START, 16'h7FFF, 1'b0);
        repeat (8) send_item(scps_pkg::OP_TICK, any16(), 1'b0);
        // zero count still waits out the start delay
        write_reg(scps_pkg::REG_STEP_MODE, 16'(scps_pkg::MODE_FULL));
        write_reg(scps_pkg::REG_PHASE_DELAY, 16'd1);
        write_reg(scps_pkg::REG_START_DELAY, 16'd2);
        send_item(scps_pkg::OP_START, 16'd0, 1'b0);
        send_item(scps_pkg::OP_TICK, any16(), 1'b1);
        send_item(scps_pkg::OP_TICK, any16(), 1'b0);
        // max delays and count, then delays lowered and mode changed mid-move
        write_reg(scps_pkg::REG_STEP_MODE, 16'(scps_pkg::MODE_WAVE));
        write_reg(scps_pkg::REG_PHASE_DELAY, 16'hFFFF);
        write_reg(scps_pkg::REG_START_DELAY, 16'hFFFF);
        send_item(scps_pkg::OP_START, 16'h7FFF, 1'b1);
        send_item(scps_pkg::OP_TICK, any16(), 1'b0);
        write_reg(scps_pkg::REG_START_DELAY, 16'd1);
        send_item(scps_pkg::OP_TICK, any16(), 1'b1);
        write_reg(scps_pkg::REG_STEP_MODE, 16'(scps_pkg::MODE_HALF));
        send_item(scps_pkg::OP_TICK, any16(), 1'b0);
        write_reg(scps_pkg::REG_PHASE_DELAY, 16'd1);
        send_item(scps_pkg::OP_TICK, any16(), 1'b1);
        send_item(scps_pkg::OP_STOP, any16(), 1'b0);
        write_reg(scps_pkg::REG_START_DELAY, 16'd0);
        write_reg(scps_pkg::REG_UNUSED, any16());

        sent = 0;
        while (sent < 1500)
        begin
            calm = (sent >= 500 && sent < 800);
            if ($urandom_range(0, 3) == 0)
            begin
                word = any16();
                pick = $urandom_range(0, 99);
                word[1:0] = (pick < 8) ? scps_pkg::MODE_BAD : 2'($urandom_range(0, 2));
                write_reg(scps_pkg::REG_STEP_MODE, word);
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    word = 16'd0;
                else if (pick < 6)
                    word = 16'hFFFF;
                else if (pick < 9)
                    word = any16();
                else
                    word = 16'($urandom_range(1, 3));
                write_reg(scps_pkg::REG_PHASE_DELAY, word);
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    word = 16'd0;
                else if (pick < 90)
                    word = 16'($urandom_range(1, 3));
                else if (pick < 95)
                    word = 16'hFFFF;
                else
                    word = any16();
                write_reg(scps_pkg::REG_START_DELAY, word);
                if ($urandom_range(0, 19) == 0)
                    write_reg(scps_pkg::REG_UNUSED, any16());
            end

            pick = $urandom_range(0, 99);
            cnt  = any16();
            if (pick < 8)
                cnt[15] = 1'b1;
            else if (pick < 13)
                cnt[15] = 1'b0;
            else if (pick < 33)
                cnt = 16'd0;
            else
                cnt = 16'($urandom_range(1, 3));
            ccw = 1'($urandom());
            send_item(scps_pkg::OP_START, cnt, ccw);
            sent++;

            plen = (cur_mode == scps_pkg::MODE_HALF) ? 8 : 4;
            need = longint'(cur_start_delay) + 2 + longint'(plen) * longint'(cnt[14:0])
                   * ((cur_phase_delay == 0) ? 1 : longint'(cur_phase_delay));
            n_ticks = (need > 80) ? $urandom_range(5, 40) : int'(need) + $urandom_range(0, 3);

            for (int k = 0; k < n_ticks; k++)
            begin
                if (k == n_ticks / 2 && $urandom_range(0, 19) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        write_reg(scps_pkg::REG_PHASE_DELAY, 16'($urandom_range(1, 3)));
                    else
                        write_reg(scps_pkg::REG_START_DELAY, 16'($urandom_range(0, 2)));
                end
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    send_item(scps_pkg::OP_STOP, any16(), 1'($urandom()));
                    sent++;
                end
                else if (pick < 6)
                begin
                    send_item(scps_pkg::OP_START, any16(), 1'($urandom()));
                    sent++;
                end
                else if (pick < 8)
                    send_item(scps_pkg::OP_NONE, any16(), 1'($urandom()));
                else
                begin
                    send_item(scps_pkg::OP_TICK, any16(), 1'($urandom()));
                    sent++;
                end
            end
            if (need > 80 || $urandom_range(0, 9) == 0)
            begin
                send_item(scps_pkg::OP_STOP, any16(), 1'($urandom()));
                sent++;
            end
        end

        calm = 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/scps_pkg.sv
rtl/core/scps_next_state.sv
rtl/core/scps_out_buf.sv
rtl/core/stepper_coil_phase_sequencer.sv
bench/testbench.sv
